// ===== sv/bis_pkg.sv =====
package bis_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int MAX_BLOCKS_DEF   = 16;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int RES_W  = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_BMAX  = 2'd0,
        CMD_ELEM  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic elem_we;
        logic elem_re;
        logic bmax_we;
        logic size_we;
        logic blk_re;
        logic size_clear;
    } mem_ctl_t;

endpackage

// ===== sv/bis_elem_ram.sv =====
module bis_elem_ram #(
    parameter int MAX_ELEMENTS = bis_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic                                re,
    input  logic [$clog2(MAX_ELEMENTS)-1:0]     addr,
    input  logic [bis_pkg::DATA_W-1:0]          wdata,
    output logic [bis_pkg::DATA_W-1:0]          rdata
);

    logic [bis_pkg::DATA_W-1:0] mem [MAX_ELEMENTS];
    logic [bis_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bis_block_ram.sv =====
module bis_block_ram #(
    parameter int MAX_ELEMENTS = bis_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_BLOCKS   = bis_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  bis_pkg::mem_ctl_t                               ctl,
    input  logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] addr,
    input  logic [bis_pkg::DATA_W-1:0]                      bmax_wdata,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0]               size_wdata,
    output logic [bis_pkg::DATA_W-1:0]                      bmax_rdata,
    output logic [$clog2(MAX_ELEMENTS+1)-1:0]               size_rdata
);

    localparam int EW = $clog2(MAX_ELEMENTS + 1);

    logic [bis_pkg::DATA_W-1:0] bmax_mem [MAX_BLOCKS];
    logic [EW-1:0]              size_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0]      size_valid_reg;
    logic [bis_pkg::DATA_W-1:0] bmax_rd_reg;
    logic [EW-1:0]              size_rd_reg;
    logic                       size_vld_rd_reg;

    always_ff @(posedge aclk) begin
        if (ctl.bmax_we) begin
            bmax_mem[addr] <= bmax_wdata;
        end
        if (ctl.size_we) begin
            size_mem[addr] <= size_wdata;
        end
        if (ctl.blk_re) begin
            bmax_rd_reg <= bmax_mem[addr];
            size_rd_reg <= size_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_valid_reg  <= '0;
            size_vld_rd_reg <= 1'b0;
        end else begin
            if (ctl.size_clear) begin
                size_valid_reg <= '0;
            end else if (ctl.size_we) begin
                size_valid_reg[addr] <= 1'b1;
            end
            if (ctl.blk_re) begin
                size_vld_rd_reg <= size_valid_reg[addr];
            end
        end
    end

    assign bmax_rdata = bmax_rd_reg;
    assign size_rdata = size_vld_rd_reg ? size_rd_reg : '0;

endmodule

// ===== sv/bis_ctrl.sv =====
module bis_ctrl #(
    parameter int MAX_ELEMENTS = bis_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_BLOCKS   = bis_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_valid,
    output logic                                            s_ready,
    input  logic [bis_pkg::CMD_W-1:0]                       s_cmd,
    input  logic [bis_pkg::DATA_W-1:0]                      s_value,
    output logic                                            m_valid,
    input  logic                                            m_ready,
    output logic                                            m_found,
    output logic [bis_pkg::RES_W-1:0]                       m_position,
    output logic [bis_pkg::RES_W-1:0]                       m_comparisons,
    output bis_pkg::mem_ctl_t                               ctl,
    output logic [$clog2(MAX_ELEMENTS)-1:0]                 elem_addr,
    input  logic [bis_pkg::DATA_W-1:0]                      elem_rdata,
    output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] blk_addr,
    output logic [bis_pkg::DATA_W-1:0]                      wr_value,
    output logic [$clog2(MAX_ELEMENTS+1)-1:0]               size_wdata,
    input  logic [bis_pkg::DATA_W-1:0]                      bmax_rdata,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0]               size_rdata
);

    localparam int EA  = $clog2(MAX_ELEMENTS);
    localparam int EW  = $clog2(MAX_ELEMENTS + 1);
    localparam int BA  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BW  = $clog2(MAX_BLOCKS + 1);
    localparam int CW  = $clog2(MAX_ELEMENTS + MAX_BLOCKS + 2);
    localparam int PXW = (EW > bis_pkg::RES_W) ? EW : bis_pkg::RES_W;
    localparam int CXW = (CW > bis_pkg::RES_W) ? CW : bis_pkg::RES_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ELEM = 6'b000010,
        ST_IDX  = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_CMP  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [EW-1:0]              ecount_reg, ecount_next;
    logic [BW-1:0]              bmcount_reg, bmcount_next;
    logic [BA-1:0]              cb_reg, cb_next;
    logic [EW-1:0]              cur_size_reg, cur_size_next;
    logic [bis_pkg::DATA_W-1:0] val_reg, val_next;
    logic [BA-1:0]              blk_reg, blk_next;
    logic [CW-1:0]              cmp_reg, cmp_next;
    logic [EW-1:0]              before_reg, before_next;
    logic [EW-1:0]              pos_reg, pos_next;
    logic [EW-1:0]              rem_reg, rem_next;
    logic                       res_found_reg, res_found_next;
    logic [bis_pkg::RES_W-1:0]  res_pos_reg, res_pos_next;
    logic [bis_pkg::RES_W-1:0]  res_cmp_reg, res_cmp_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       m_found_reg, m_found_next;
    logic [bis_pkg::RES_W-1:0]  m_pos_reg, m_pos_next;
    logic [bis_pkg::RES_W-1:0]  m_cmp_reg, m_cmp_next;

    logic                       advance;
    logic [BA-1:0]              cb_new;
    logic [EW-1:0]              size_new;
    logic [PXW-1:0]             pos_ext;
    logic [CXW-1:0]             cmp_ext;

    always_comb begin
        advance  = ((BW'(cb_reg) + BW'(1)) < bmcount_reg) &&
                   ($signed(bmax_rdata) < $signed(val_reg));
        cb_new   = advance ? BA'(cb_reg + BA'(1)) : cb_reg;
        size_new = advance ? EW'(1) : EW'(cur_size_reg + EW'(1));
        pos_ext  = PXW'(pos_reg + EW'(1));
        cmp_ext  = CXW'(cmp_reg);
    end

    always_comb begin
        state_next     = state_reg;
        ecount_next    = ecount_reg;
        bmcount_next   = bmcount_reg;
        cb_next        = cb_reg;
        cur_size_next  = cur_size_reg;
        val_next       = val_reg;
        blk_next       = blk_reg;
        cmp_next       = cmp_reg;
        before_next    = before_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_cmp_next   = res_cmp_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_pos_next     = m_pos_reg;
        m_cmp_next     = m_cmp_reg;
        ctl            = '0;
        elem_addr      = EA'(pos_reg);
        blk_addr       = blk_reg;
        wr_value       = val_reg;
        size_wdata     = size_new;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    val_next = s_value;
                    case (bis_pkg::cmd_t'(s_cmd))
                        bis_pkg::CMD_BMAX: begin
                            if (bmcount_reg < BW'(MAX_BLOCKS)) begin
                                ctl.bmax_we  = 1'b1;
                                blk_addr     = BA'(bmcount_reg);
                                wr_value     = s_value;
                                bmcount_next = BW'(bmcount_reg + BW'(1));
                            end
                        end
                        bis_pkg::CMD_ELEM: begin
                            if (ecount_reg < EW'(MAX_ELEMENTS)) begin
                                ctl.blk_re = 1'b1;
                                blk_addr   = cb_reg;
                                state_next = ST_ELEM;
                            end
                        end
                        bis_pkg::CMD_QUERY: begin
                            cmp_next    = CW'(1);
                            before_next = '0;
                            blk_next    = '0;
                            if (bmcount_reg == '0) begin
                                res_found_next = 1'b0;
                                res_pos_next   = '0;
                                res_cmp_next   = '0;
                                state_next     = ST_OUT;
                            end else begin
                                ctl.blk_re = 1'b1;
                                blk_addr   = '0;
                                state_next = ST_IDX;
                            end
                        end
                        bis_pkg::CMD_CLEAR: begin
                            ctl.size_clear = 1'b1;
                            ecount_next    = '0;
                            bmcount_next   = '0;
                            cb_next        = '0;
                            cur_size_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ELEM: begin
                ctl.elem_we   = 1'b1;
                elem_addr     = EA'(ecount_reg);
                wr_value      = val_reg;
                ctl.size_we   = 1'b1;
                blk_addr      = cb_new;
                size_wdata    = size_new;
                cb_next       = cb_new;
                cur_size_next = size_new;
                ecount_next   = EW'(ecount_reg + EW'(1));
                state_next    = ST_IDLE;
            end
            ST_IDX: begin
                if ($signed(val_reg) > $signed(bmax_rdata)) begin
                    cmp_next    = CW'(cmp_reg + CW'(1));
                    before_next = EW'(before_reg + size_rdata);
                    if ((BW'(blk_reg) + BW'(1)) >= bmcount_reg) begin
                        res_found_next = 1'b0;
                        res_pos_next   = '0;
                        res_cmp_next   = '0;
                        state_next     = ST_OUT;
                    end else begin
                        blk_next   = BA'(blk_reg + BA'(1));
                        ctl.blk_re = 1'b1;
                        blk_addr   = BA'(blk_reg + BA'(1));
                    end
                end else begin
                    pos_next   = before_reg;
                    rem_next   = size_rdata;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((rem_reg == '0) || (pos_reg >= ecount_reg)) begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    res_cmp_next   = '0;
                    state_next     = ST_OUT;
                end else begin
                    ctl.elem_re = 1'b1;
                    elem_addr   = EA'(pos_reg);
                    cmp_next    = CW'(cmp_reg + CW'(1));
                    state_next  = ST_CMP;
                end
            end
            ST_CMP: begin
                if (elem_rdata == val_reg) begin
                    res_found_next = 1'b1;
                    res_pos_next   = pos_ext[bis_pkg::RES_W-1:0];
                    res_cmp_next   = cmp_ext[bis_pkg::RES_W-1:0];
                    state_next     = ST_OUT;
                end else begin
                    pos_next   = EW'(pos_reg + EW'(1));
                    rem_next   = EW'(rem_reg - EW'(1));
                    state_next = ST_SCAN;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_pos_next   = res_pos_reg;
                    m_cmp_next   = res_cmp_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ecount_reg   <= '0;
            bmcount_reg  <= '0;
            cb_reg       <= '0;
            cur_size_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ecount_reg   <= ecount_next;
            bmcount_reg  <= bmcount_next;
            cb_reg       <= cb_next;
            cur_size_reg <= cur_size_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg       <= val_next;
        blk_reg       <= blk_next;
        cmp_reg       <= cmp_next;
        before_reg    <= before_next;
        pos_reg       <= pos_next;
        rem_reg       <= rem_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_cmp_reg   <= res_cmp_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
        m_cmp_reg     <= m_cmp_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_position    = m_pos_reg;
    assign m_comparisons = m_cmp_reg;

endmodule

// ===== sv/block_index_search.sv =====
// Indexed block search table with a command stream in and a result stream out.
// Slave channel: s_tuser carries the command (append block maximum, append
// element, query key, clear); s_tdata carries the signed 32-bit value.
// Master channel: one transfer per query only; m_tuser is the found flag,
// m_tdata holds the 1-based position and the comparison count (zeros on miss).
// Steps per command: block maximum append and clear are done from idle; element
// append does one block memory read to fetch the current block maximum,
// then the element and block size writes. A query starts with a read of the
// first block maximum, compares block maxima (one block memory read each),
// scans elements (element memory read, then compare), takes a further step
// when the scan ends without a match, and then posts the result; a query
// with no block maxima loaded goes straight to posting the result.
// One command is in work at a time; s_tready is high while the sequencer idles.
// Reset empties the table: counts, current block and block sizes go to zero.
// The result sits in an output register; while the receiver stalls, the next
// command is still taken, and a following query holds in its final cycle
// until that register is free.
module block_index_search #(
    parameter int MAX_ELEMENTS = bis_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_BLOCKS   = bis_pkg::MAX_BLOCKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_value[31:0]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // position[10:0], comparisons[21:11], zero pad
    output logic        m_tuser    // found
);

    localparam int EA = $clog2(MAX_ELEMENTS);
    localparam int EW = $clog2(MAX_ELEMENTS + 1);
    localparam int BA = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    bis_pkg::mem_ctl_t          ctl;
    logic [EA-1:0]              elem_addr;
    logic [bis_pkg::DATA_W-1:0] elem_rdata;
    logic [BA-1:0]              blk_addr;
    logic [bis_pkg::DATA_W-1:0] wr_value;
    logic [EW-1:0]              size_wdata;
    logic [bis_pkg::DATA_W-1:0] bmax_rdata;
    logic [EW-1:0]              size_rdata;
    logic [bis_pkg::RES_W-1:0]  position;
    logic [bis_pkg::RES_W-1:0]  comparisons;

    bis_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .s_cmd         (s_tuser),
        .s_value       (s_tdata),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_found       (m_tuser),
        .m_position    (position),
        .m_comparisons (comparisons),
        .ctl           (ctl),
        .elem_addr     (elem_addr),
        .elem_rdata    (elem_rdata),
        .blk_addr      (blk_addr),
        .wr_value      (wr_value),
        .size_wdata    (size_wdata),
        .bmax_rdata    (bmax_rdata),
        .size_rdata    (size_rdata)
    );

    bis_elem_ram #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_elem_ram (
        .aclk  (aclk),
        .we    (ctl.elem_we),
        .re    (ctl.elem_re),
        .addr  (elem_addr),
        .wdata (wr_value),
        .rdata (elem_rdata)
    );

    bis_block_ram #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_block_ram (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .addr       (blk_addr),
        .bmax_wdata (wr_value),
        .size_wdata (size_wdata),
        .bmax_rdata (bmax_rdata),
        .size_rdata (size_rdata)
    );

    assign m_tdata = {2'b00, comparisons, position};

endmodule
